[rtl/multi_slot_countdown_timer_bank_top_macros.svh]
// assertion macros for the countdown timer bank checker
// no dependencies; included by the checker file only
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_BANK_TOP_MACROS_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_BANK_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSTB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// next-cycle implication, disabled during reset
`define MSTB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

[rtl/mstb_pkg.sv]
// shared types and codes for the countdown timer bank
// no dependencies; imported by every module of the block
`default_nettype none

package mstb_pkg;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 32;
    localparam int MODE_W   = 2;
    localparam int TICK_W   = 32;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

    // classified operations handed to the engine
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_START   = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd4;
    localparam logic [OP_W-1:0] OP_BAD     = 3'd5;

    localparam logic [MODE_W-1:0] MODE_DISABLED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONESHOT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTORELOAD = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // expiries reported per sweep
    localparam int MAX_RESULTS = 16;
    localparam int REP_W       = $clog2(MAX_RESULTS + 1);

    // command queue between front and engine
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [OP_W-1:0]     kind;
        logic                in_range;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic [MODE_W-1:0]   run_mode;
        logic [TICK_W-1:0]   now_tick;
    } op_t;

endpackage

`default_nettype wire

[rtl/mstb_front.sv]
// front end: accepts input beats and classifies them into queue entries
// depends on mstb_pkg
`default_nettype none

module mstb_front #(
    parameter int SLOTS = 16
) (
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mstb_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [mstb_pkg::SLOT_W-1:0]   s_slot,
    input  wire logic [mstb_pkg::PERIOD_W-1:0] s_period,
    input  wire logic [mstb_pkg::MODE_W-1:0]   s_run_mode,
    input  wire logic [mstb_pkg::TICK_W-1:0]   s_now_tick,
    input  wire logic                          q_full,
    output logic                               q_push,
    output mstb_pkg::op_t                      q_op
);
    import mstb_pkg::*;

    logic [8:0] slot_ext;

    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;
    assign slot_ext = {5'd0, s_slot};

    always_comb begin
        case (s_cmd)
            CMD_TICK:    q_op.kind = OP_TICK;
            CMD_CREATE:  q_op.kind = OP_CREATE;
            CMD_START:   q_op.kind = OP_START;
            CMD_CANCEL:  q_op.kind = OP_CANCEL;
            CMD_DESTROY: q_op.kind = OP_DESTROY;
            default:     q_op.kind = OP_BAD;
        endcase
        q_op.in_range = (slot_ext < 9'(SLOTS));
        q_op.slot     = s_slot;
        q_op.period   = s_period;
        q_op.run_mode = s_run_mode;
        q_op.now_tick = s_now_tick;
    end

endmodule

`default_nettype wire

[rtl/mstb_fifo.sv]
// short command queue between the front end and the engine
// depends on mstb_pkg
`default_nettype none

module mstb_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  mstb_pkg::op_t      push_op,
    output logic               full,
    input  wire logic          pop,
    output mstb_pkg::op_t      pop_op,
    output logic               valid
);
    import mstb_pkg::*;

    op_t               ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_op  = ent_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

[rtl/mstb_engine.sv]
// back end: slot state, countdown sweep and result register
// depends on mstb_pkg; fed by mstb_fifo
`default_nettype none

module mstb_engine #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  mstb_pkg::op_t                    q_op,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_kind,
    output logic [mstb_pkg::SLOT_W-1:0]      m_slot_out,
    output logic                             m_status,
    output logic                             m_last
);
    import mstb_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_CREATE = 3'd3;
    localparam logic [2:0] ST_START  = 3'd4;

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
        logic [8:0] ext;
        ext = 9'(idx);
        return ext[SLOT_W-1:0];
    endfunction

    // slot memories
    logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
    logic [COUNT_BITS-1:0] per_mem [SLOTS];
    logic [COUNT_BITS-1:0] cnt_q, per_q;

    // per-slot flags
    logic [SLOTS-1:0]  used_reg;
    logic [MODE_W-1:0] mode_reg [SLOTS];

    logic [2:0]            state_reg, state_next;
    logic [TICK_W-1:0]     prev_tick_reg, prev_tick_next;
    logic [TICK_W-1:0]     diff_reg, diff_next;
    logic                  issue_reg, issue_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [REP_W-1:0]      rep_cnt_reg, rep_cnt_next;
    logic [IDX_W-1:0]      work_idx_reg, work_idx_next;
    logic [COUNT_BITS-1:0] op_period_reg, op_period_next;
    logic [MODE_W-1:0]     op_mode_reg, op_mode_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_status_reg, out_last_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    // strobes into memories, flags and the result register
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  cnt_we, per_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  used_we, used_wdata;
    logic [IDX_W-1:0]      used_widx;
    logic                  mode_we;
    logic [IDX_W-1:0]      mode_widx;
    logic [MODE_W-1:0]     mode_wdata;
    logic                  out_load, ld_kind, ld_status, ld_last;
    logic [SLOT_W-1:0]     ld_slot;

    logic [8:0]            q_slot_ext;
    logic [IDX_W-1:0]      q_idx;
    logic [CMP_W-1:0]      q_period_ext;
    logic                  q_slot_live;
    logic                  out_free;
    logic                  ev_active, ev_expire, ev_report, sweep_stall;
    logic [MODE_W-1:0]     ev_mode;
    logic [CMP_W-1:0]      cnt_ext, diff_ext, ev_sub;

    assign q_slot_ext   = {5'd0, q_op.slot};
    assign q_idx        = q_slot_ext[IDX_W-1:0];
    assign q_period_ext = CMP_W'(q_op.period);
    assign q_slot_live  = q_op.in_range && used_reg[q_idx];
    assign out_free     = !out_valid_reg || m_ready;

    // evaluate stage of the sweep
    assign ev_mode     = mode_reg[ev_idx_reg];
    assign ev_active   = used_reg[ev_idx_reg] && (ev_mode != MODE_DISABLED);
    assign cnt_ext     = CMP_W'(cnt_q);
    assign diff_ext    = CMP_W'(diff_reg);
    assign ev_sub      = cnt_ext - diff_ext;
    assign ev_expire   = ev_active && !(cnt_ext > diff_ext);
    assign ev_report   = ev_expire && (rep_cnt_reg < REP_W'(MAX_RESULTS));
    // a second expiry needs the held one to leave first
    assign sweep_stall = ev_valid_reg && ev_report && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        prev_tick_next  = prev_tick_reg;
        diff_next       = diff_reg;
        issue_next      = issue_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        rep_cnt_next    = rep_cnt_reg;
        work_idx_next   = work_idx_reg;
        op_period_next  = op_period_reg;
        op_mode_next    = op_mode_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = rd_idx_reg;
        cnt_we     = 1'b0;
        per_we     = 1'b0;
        mem_waddr  = ev_idx_reg;
        cnt_wdata  = ev_sub[COUNT_BITS-1:0];
        used_we    = 1'b0;
        used_wdata = 1'b0;
        used_widx  = work_idx_reg;
        mode_we    = 1'b0;
        mode_widx  = ev_idx_reg;
        mode_wdata = MODE_DISABLED;
        out_load   = 1'b0;
        ld_kind    = KIND_STATUS;
        ld_slot    = q_op.slot;
        ld_status  = STATUS_FAIL;
        ld_last    = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_op.kind)
                        OP_TICK: begin
                            q_pop = 1'b1;
                            if (prev_tick_reg == '0) begin
                                prev_tick_next = q_op.now_tick;
                            end else if (q_op.now_tick != prev_tick_reg) begin
                                prev_tick_next  = q_op.now_tick;
                                diff_next       = q_op.now_tick - prev_tick_reg;
                                rd_idx_next     = '0;
                                issue_next      = 1'b1;
                                ev_valid_next   = 1'b0;
                                pend_valid_next = 1'b0;
                                rep_cnt_next    = '0;
                                state_next      = ST_SWEEP;
                            end
                        end
                        OP_CREATE: begin
                            q_pop          = 1'b1;
                            work_idx_next  = '0;
                            op_period_next = q_period_ext[COUNT_BITS-1:0];
                            state_next     = ST_CREATE;
                        end
                        OP_START: begin
                            if (q_slot_live) begin
                                q_pop         = 1'b1;
                                rd_en         = 1'b1;
                                rd_addr       = q_idx;
                                work_idx_next = q_idx;
                                op_mode_next  = q_op.run_mode;
                                state_next    = ST_START;
                            end else if (out_free) begin
                                q_pop    = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                        OP_CANCEL, OP_DESTROY: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                out_load = 1'b1;
                                if (q_slot_live) begin
                                    ld_status = STATUS_OK;
                                    mode_we   = 1'b1;
                                    mode_widx = q_idx;
                                    if (q_op.kind == OP_DESTROY) begin
                                        used_we   = 1'b1;
                                        used_widx = q_idx;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                if (!sweep_stall) begin
                    if (issue_reg) begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg;
                        if (rd_idx_reg == LAST_IDX) begin
                            issue_next = 1'b0;
                        end else begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end else begin
                        ev_valid_next = 1'b0;
                    end
                    if (ev_valid_reg && ev_active) begin
                        cnt_we = 1'b1;
                        if (ev_expire) begin
                            if (ev_mode == MODE_AUTORELOAD) begin
                                cnt_wdata = per_q;
                            end else begin
                                cnt_wdata = '0;
                                mode_we   = 1'b1;
                            end
                        end
                    end
                    if (ev_valid_reg && ev_report) begin
                        rep_cnt_next    = rep_cnt_reg + 1'b1;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ev_idx_reg;
                        if (pend_valid_reg) begin
                            out_load  = 1'b1;
                            ld_kind   = KIND_EXPIRY;
                            ld_slot   = idx_to_slot(pend_idx_reg);
                            ld_status = STATUS_OK;
                            ld_last   = 1'b0;
                        end
                    end
                    if (!issue_reg && !ev_valid_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                // the held expiry is the last one of the sweep
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    ld_kind         = KIND_EXPIRY;
                    ld_slot         = idx_to_slot(pend_idx_reg);
                    ld_status       = STATUS_OK;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_CREATE: begin
                // lowest free slot, one slot per cycle
                if (!used_reg[work_idx_reg]) begin
                    if (out_free) begin
                        used_we    = 1'b1;
                        used_wdata = 1'b1;
                        mode_we    = 1'b1;
                        mode_widx  = work_idx_reg;
                        cnt_we     = 1'b1;
                        per_we     = 1'b1;
                        mem_waddr  = work_idx_reg;
                        cnt_wdata  = op_period_reg;
                        out_load   = 1'b1;
                        ld_slot    = idx_to_slot(work_idx_reg);
                        ld_status  = STATUS_OK;
                        state_next = ST_IDLE;
                    end
                end else if (work_idx_reg == LAST_IDX) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        ld_slot    = '0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    work_idx_next = work_idx_reg + 1'b1;
                end
            end

            ST_START: begin
                if (out_free) begin
                    cnt_we     = 1'b1;
                    mem_waddr  = work_idx_reg;
                    cnt_wdata  = per_q;
                    mode_we    = 1'b1;
                    mode_widx  = work_idx_reg;
                    mode_wdata = op_mode_reg;
                    out_load   = 1'b1;
                    ld_slot    = idx_to_slot(work_idx_reg);
                    ld_status  = STATUS_OK;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !m_ready;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_tick_reg  <= '0;
            issue_reg      <= 1'b0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_tick_reg  <= prev_tick_next;
            issue_reg      <= issue_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg      <= diff_next;
        rd_idx_reg    <= rd_idx_next;
        ev_idx_reg    <= ev_idx_next;
        pend_idx_reg  <= pend_idx_next;
        work_idx_reg  <= work_idx_next;
        op_period_reg <= op_period_next;
        op_mode_reg   <= op_mode_next;
        if (out_load) begin
            out_kind_reg   <= ld_kind;
            out_slot_reg   <= ld_slot;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                mode_reg[i] <= MODE_DISABLED;
            end
        end else begin
            if (used_we) begin
                used_reg[used_widx] <= used_wdata;
            end
            if (mode_we) begin
                mode_reg[mode_widx] <= mode_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[mem_waddr] <= cnt_wdata;
        end
        if (per_we) begin
            per_mem[mem_waddr] <= op_period_reg;
        end
        if (rd_en) begin
            cnt_q <= cnt_mem[rd_addr];
            per_q <= per_mem[rd_addr];
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_slot_out = out_slot_reg;
    assign m_status   = out_status_reg;
    assign m_last     = out_last_reg;

endmodule

`default_nettype wire

[rtl/multi_slot_countdown_timer_bank_top.sv]
// Bank of SLOTS countdown timers driven by a command stream (tick, create, start, cancel,
// destroy). Input beats on s_*, result beats on m_*, both valid/ready.
// Non-tick commands give one status beat with m_last set. A tick that changes the count
// sweeps all slots in rising order and gives one expiry beat per expiring slot (first 16),
// m_last on the final one; first, unchanged or expiry-free ticks give no beat.
// A changed tick holds the engine for its sweep, one slot per cycle unless a receiver
// stall holds it, through the countdown and period memories. Cancel, destroy and bad
// commands load their status straight from the queue head, start first reads the slot
// period, and create first scans for the lowest free slot. The engine takes the next
// command only once the current one is done.
// A two-entry command queue sits between the front end and the engine, and a result
// register sits at m_*, so inputs are taken while a result waits.
// When the receiver stalls, the engine holds its sweep once it has a second expiry to
// hand over; the queue then fills and s_ready falls.
// Reset (aresetn low, synchronous) frees all slots, disables them and clears the
// recorded tick; periods and countdowns are written by create before use.
// depends on mstb_pkg, mstb_front, mstb_fifo, mstb_engine
`default_nettype none

module multi_slot_countdown_timer_bank_top #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mstb_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [mstb_pkg::SLOT_W-1:0]   s_slot,
    input  wire logic [mstb_pkg::PERIOD_W-1:0] s_period,
    input  wire logic [mstb_pkg::MODE_W-1:0]   s_run_mode,
    input  wire logic [mstb_pkg::TICK_W-1:0]   s_now_tick,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [mstb_pkg::SLOT_W-1:0]        m_slot_out,
    output logic                               m_status,
    output logic                               m_last
);
    import mstb_pkg::*;

    op_t  push_op, pop_op;
    logic q_push, q_full, q_pop, q_valid;

    mstb_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_slot     (s_slot),
        .s_period   (s_period),
        .s_run_mode (s_run_mode),
        .s_now_tick (s_now_tick),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (push_op)
    );

    mstb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .valid   (q_valid)
    );

    mstb_engine #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_op       (pop_op),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_slot_out (m_slot_out),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

[rtl/mstb_checker.sv]
// port-level checks on the countdown timer bank result channel
// depends on mstb_pkg and the macro header; bound to the top level below
`default_nettype none
`include "multi_slot_countdown_timer_bank_top_macros.svh"

module mstb_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic                        m_kind,
    input wire logic [mstb_pkg::SLOT_W-1:0] m_slot_out,
    input wire logic                        m_status,
    input wire logic                        m_last
);
    import mstb_pkg::*;

    // a stalled result beat holds
    `MSTB_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_slot_out) && $stable(m_kind) && $stable(m_last))
    // expiry beats never report failure
    `MSTB_ASSERT_IMPL(a_expiry_ok, aclk, aresetn, m_valid && (m_kind == KIND_EXPIRY), m_status == STATUS_OK)
    // a status beat is always the only beat of its command
    `MSTB_ASSERT_IMPL(a_status_last, aclk, aresetn, m_valid && (m_kind == KIND_STATUS), m_last)
    // after a beat without last leaves, a beat is valid at once or m_kind still shows an expiry
    `MSTB_ASSERT_NEXT(a_no_split, aclk, aresetn, m_valid && m_ready && !m_last, m_valid || (m_kind == KIND_EXPIRY))

endmodule

bind multi_slot_countdown_timer_bank_top mstb_checker u_mstb_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_slot_out (m_slot_out),
    .m_status   (m_status),
    .m_last     (m_last)
);

`default_nettype wire

[tb/sv/mstb_checker.sv]
// result checker for the countdown timer bank: watches both channels, predicts beats
// from its own copy of the slot state and compares them in order; depends on mstb_pkg
module mstb_scoreboard #(
    parameter int SLOTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [mstb_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [mstb_pkg::SLOT_W-1:0]   s_slot,
    input  wire logic [mstb_pkg::PERIOD_W-1:0] s_period,
    input  wire logic [mstb_pkg::MODE_W-1:0]   s_run_mode,
    input  wire logic [mstb_pkg::TICK_W-1:0]   s_now_tick,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic                          m_kind,
    input  wire logic [mstb_pkg::SLOT_W-1:0]   m_slot_out,
    input  wire logic                          m_status,
    input  wire logic                          m_last,
    output int                                 errors,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mstb_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              status;
        logic              last;
    } beat_t;

    beat_t               pending_beats[$];
    logic                timer_used   [SLOTS];
    logic [MODE_W-1:0]   timer_mode   [SLOTS];
    logic [PERIOD_W-1:0] timer_period [SLOTS];
    logic [PERIOD_W-1:0] timer_left   [SLOTS];
    logic [TICK_W-1:0]   recorded_tick;
    int                  fail_count = 0;

    function automatic beat_t make_beat(logic kind, logic [SLOT_W-1:0] slot, logic status,
                                        logic last);
        beat_t b;
        b.kind   = kind;
        b.slot   = slot;
        b.status = status;
        b.last   = last;
        return b;
    endfunction

    task automatic clear_timers();
        for (int i = 0; i < SLOTS; i++) begin
            timer_used[i]   = 1'b0;
            timer_mode[i]   = MODE_DISABLED;
            timer_period[i] = '0;
            timer_left[i]   = '0;
        end
        recorded_tick = '0;
        pending_beats.delete();
    endtask

    // one beat is held back so the final expiry of the sweep can carry last
    task automatic sweep_timers(input logic [TICK_W-1:0] elapsed);
        beat_t held;
        bit    have_held;
        int    reported;
        have_held = 1'b0;
        reported  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!timer_used[i] || timer_mode[i] == MODE_DISABLED) continue;
            if (timer_left[i] > elapsed) timer_left[i] = timer_left[i] - elapsed;
            else timer_left[i] = '0;
            if (timer_left[i] == '0) begin
                if (reported < MAX_RESULTS) begin
                    if (have_held) pending_beats.push_back(held);
                    held      = make_beat(KIND_EXPIRY, SLOT_W'(i), STATUS_OK, 1'b0);
                    have_held = 1'b1;
                    reported++;
                end
                if (timer_mode[i] == MODE_AUTORELOAD) timer_left[i] = timer_period[i];
                else timer_mode[i] = MODE_DISABLED;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_beats.push_back(held);
        end
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                 input logic [PERIOD_W-1:0] period,
                                 input logic [MODE_W-1:0] run_mode,
                                 input logic [TICK_W-1:0] now_tick);
        logic [SLOT_W-1:0] target;
        logic              status;
        target = slot;
        status = STATUS_FAIL;
        case (cmd)
            CMD_TICK: begin
                // a zero recorded count means nothing recorded yet
                if (recorded_tick == '0) begin
                    recorded_tick = now_tick;
                end else if (now_tick != recorded_tick) begin
                    sweep_timers(now_tick - recorded_tick);
                    recorded_tick = now_tick;
                end
                return;
            end
            CMD_CREATE: begin
                target = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!timer_used[i]) begin
                        timer_used[i]   = 1'b1;
                        timer_period[i] = period;
                        timer_left[i]   = period;
                        timer_mode[i]   = MODE_DISABLED;
                        target          = SLOT_W'(i);
                        status          = STATUS_OK;
                        break;
                    end
                end
            end
            CMD_START, CMD_CANCEL, CMD_DESTROY: begin
                if (int'(slot) < SLOTS && timer_used[slot]) begin
                    status = STATUS_OK;
                    if (cmd == CMD_START) begin
                        timer_left[slot] = timer_period[slot];
                        timer_mode[slot] = run_mode;
                    end else if (cmd == CMD_CANCEL) begin
                        timer_mode[slot] = MODE_DISABLED;
                    end else begin
                        timer_used[slot] = 1'b0;
                        timer_mode[slot] = MODE_DISABLED;
                    end
                end
            end
            default: ;
        endcase
        pending_beats.push_back(make_beat(KIND_STATUS, target, status, 1'b1));
    endtask

    always @(posedge aclk) begin
        beat_t seen;
        beat_t want;
        if (!aresetn) begin
            clear_timers();
        end else begin
            if (m_valid && m_ready) begin
                seen = make_beat(m_kind, m_slot_out, m_status, m_last);
                if (pending_beats.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat kind=%0d slot=%0d status=%0d last=%0d",
                             $time, seen.kind, seen.slot, seen.status, seen.last);
                end else begin
                    want = pending_beats.pop_front();
                    if (seen.kind !== want.kind || seen.slot !== want.slot ||
                        seen.status !== want.status || seen.last !== want.last) begin
                        fail_count++;
                        $display({"%0t: result beat mismatch, expected kind=%0d slot=%0d ",
                                  "status=%0d last=%0d, actual kind=%0d slot=%0d ",
                                  "status=%0d last=%0d"},
                                 $time, want.kind, want.slot, want.status, want.last,
                                 seen.kind, seen.slot, seen.status, seen.last);
                    end
                end
            end
            if (s_valid && s_ready)
                apply_command(s_cmd, s_slot, s_period, s_run_mode, s_now_tick);
        end
        errors      <= fail_count;
        outstanding <= pending_beats.size();
    end

endmodule

[tb/sv/testbench.sv]
// top of the countdown timer bank testbench: clock, reset, command stimulus and verdict
// depends on mstb_pkg, mstb_scoreboard and multi_slot_countdown_timer_bank_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mstb_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RUN_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET = 360;
    localparam int SETTLE      = 3 * SLOTS + 8;

    // first of the three command codes the block does not define
    localparam logic [CMD_W-1:0]  CMD_UNUSED = CMD_DESTROY + 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE = MODE_AUTORELOAD + 2'd1;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd      = CMD_TICK;
    logic [SLOT_W-1:0]   s_slot     = '0;
    logic [PERIOD_W-1:0] s_period   = '0;
    logic [MODE_W-1:0]   s_run_mode = MODE_DISABLED;
    logic [TICK_W-1:0]   s_now_tick = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic                m_kind;
    logic [SLOT_W-1:0]   m_slot_out;
    logic                m_status;
    logic                m_last;
    int                  mismatches;
    int                  outstanding;

    int                  burst_left = 0;
    int                  sent       = 0;
    logic [SLOTS-1:0]    live       = '0;
    logic [TICK_W-1:0]   tick_now   = '0;
    int                  ready_style = 0;
    int                  ready_left  = 0;

    multi_slot_countdown_timer_bank_top #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (32)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_slot     (s_slot),
        .s_period   (s_period),
        .s_run_mode (s_run_mode),
        .s_now_tick (s_now_tick),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_slot_out (m_slot_out),
        .m_status   (m_status),
        .m_last     (m_last)
    );

    mstb_scoreboard #(
        .SLOTS (SLOTS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_slot      (s_slot),
        .s_period    (s_period),
        .s_run_mode  (s_run_mode),
        .s_now_tick  (s_now_tick),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_slot_out  (m_slot_out),
        .m_status    (m_status),
        .m_last      (m_last),
        .errors      (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // receiver: phases of always ready, coin-flip ready, and mostly stalled
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_style <= $urandom_range(0, 2);
            ready_left  <= $urandom_range(40, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                        input logic [PERIOD_W-1:0] period, input logic [MODE_W-1:0] run_mode,
                        input logic [TICK_W-1:0] now_tick);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_slot     <= slot;
        s_period   <= period;
        s_run_mode <= run_mode;
        s_now_tick <= now_tick;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent++;
        // keep track of allocated slots so commands can aim at live timers
        if (cmd == CMD_CREATE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i]) begin
                    live[i] = 1'b1;
                    break;
                end
            end
        end else if (cmd == CMD_DESTROY) begin
            live[slot] = 1'b0;
        end
    endtask

    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic tick_to(input logic [TICK_W-1:0] value);
        tick_now = value;
        send(CMD_TICK, SLOT_W'($urandom), $urandom, MODE_W'($urandom), tick_now);
    endtask

    task automatic command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [PERIOD_W-1:0] period,
                           input logic [MODE_W-1:0] run_mode);
        send(cmd, slot, period, run_mode, $urandom);
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot(bit prefer_live);
        int first;
        int idx;
        first = $urandom_range(0, SLOTS - 1);
        if (prefer_live) begin
            for (int k = 0; k < SLOTS; k++) begin
                idx = (first + k) % SLOTS;
                if (live[idx]) return SLOT_W'(idx);
            end
        end
        return SLOT_W'(first);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom;
        if (r < 18) return '0;
        return $urandom_range(1, 40);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return MODE_DISABLED;
        if (r == 1) return MODE_SPARE;
        if (r < 6) return MODE_ONESHOT;
        return MODE_AUTORELOAD;
    endfunction

    task automatic random_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) tick_to(tick_now);
        else if (r < 90) tick_to(tick_now + $urandom_range(1, 12));
        else if (r < 97) tick_to(tick_now + $urandom_range(13, 500));
        else if (r < 99) tick_to($urandom);
        else tick_to('0);
    endtask

    // fill the bank, start everything, let most timers expire in one sweep, tear down
    task automatic storm();
        wait_drained();
        while (live != '1) command(CMD_CREATE, pick_slot(0), $urandom_range(0, 3), pick_mode());
        command(CMD_CREATE, pick_slot(0), pick_period(), pick_mode());
        for (int i = 0; i < SLOTS; i++)
            command(CMD_START, SLOT_W'(i), $urandom,
                    ($urandom_range(0, 1) != 0) ? MODE_AUTORELOAD : MODE_ONESHOT);
        tick_to(tick_now + 32'h4000_0000);
        tick_to(tick_now + 32'd1);
        for (int i = 0; i < SLOTS; i++) command(CMD_DESTROY, SLOT_W'(i), $urandom, pick_mode());
    endtask

    initial begin
        int r;
        int storms_done;
        storms_done = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // tick bookkeeping: zero count, first record, unchanged count
        tick_to('0);
        tick_to(32'd100);
        tick_to(32'd100);
        // commands on unused slots and the undefined codes
        command(CMD_START, 4'd0, '1, MODE_ONESHOT);
        command(CMD_CANCEL, 4'd15, '0, MODE_AUTORELOAD);
        command(CMD_DESTROY, 4'd3, '1, MODE_SPARE);
        command(CMD_UNUSED, 4'd9, '0, MODE_DISABLED);
        command(CMD_UNUSED + 3'd1, 4'd15, '1, MODE_ONESHOT);
        command(CMD_UNUSED + 3'd2, 4'd6, '0, MODE_SPARE);
        // zero period, largest period, two small ones
        command(CMD_CREATE, 4'd0, '0, MODE_DISABLED);
        command(CMD_CREATE, 4'd0, '1, MODE_DISABLED);
        command(CMD_CREATE, 4'd0, 32'd5, MODE_DISABLED);
        command(CMD_CREATE, 4'd0, 32'd3, MODE_DISABLED);
        command(CMD_START, 4'd0, '0, MODE_AUTORELOAD);
        command(CMD_START, 4'd1, '0, MODE_ONESHOT);
        command(CMD_START, 4'd2, '0, MODE_SPARE);
        command(CMD_START, 4'd3, '0, MODE_AUTORELOAD);
        tick_to(32'd105);
        // count going backwards wraps to a huge difference
        tick_to(32'd104);
        command(CMD_CANCEL, 4'd3, '0, MODE_DISABLED);
        command(CMD_START, 4'd2, '0, MODE_DISABLED);
        command(CMD_DESTROY, 4'd1, '0, MODE_DISABLED);
        command(CMD_CREATE, 4'd0, 32'd7, MODE_DISABLED);

        while (sent < ITEM_TARGET) begin
            if (storms_done < 2 && sent > 120 + storms_done * 120) begin
                storm();
                storms_done++;
            end
            r = $urandom_range(0, 99);
            if (r < 40) random_tick();
            else if (r < 52) command(CMD_CREATE, pick_slot(0), pick_period(), pick_mode());
            else if (r < 72)
                command(CMD_START, pick_slot($urandom_range(0, 9) != 0), $urandom, pick_mode());
            else if (r < 80)
                command(CMD_CANCEL, pick_slot($urandom_range(0, 4) != 0), $urandom, pick_mode());
            else if (r < 88)
                command(CMD_DESTROY, pick_slot($urandom_range(0, 4) != 0), $urandom,
                        pick_mode());
            else if (r < 94)
                command(CMD_W'(CMD_UNUSED + $urandom_range(0, 2)), pick_slot(0), $urandom,
                        MODE_W'($urandom));
            else if (r < 96) wait_drained();
            else command(CMD_START, pick_slot(0), $urandom, MODE_W'($urandom));
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mstb_pkg.sv
rtl/mstb_front.sv
rtl/mstb_fifo.sv
rtl/mstb_engine.sv
rtl/multi_slot_countdown_timer_bank_top.sv
rtl/mstb_checker.sv
tb/sv/mstb_checker.sv
tb/sv/testbench.sv
